// File: src/wsfp_pkg.sv
// Shared types, codes and helpers of the WebSocket frame parser.
package wsfp_pkg;

    // Parse phases, one-hot
    typedef enum logic [4:0] {
        PH_HDR1 = 5'b00001,
        PH_HDR2 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_MASK = 5'b01000,
        PH_PAY  = 5'b10000
    } t_phase;

    // Opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // Action classes
    localparam logic [2:0] ACT_MID   = 3'd0;
    localparam logic [2:0] ACT_TEXT  = 3'd1;
    localparam logic [2:0] ACT_CLOSE = 3'd2;
    localparam logic [2:0] ACT_PING  = 3'd3;
    localparam logic [2:0] ACT_PONG  = 3'd4;
    localparam logic [2:0] ACT_OTHER = 3'd5;

    // Header constants
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [3:0] EXT_BYTES16 = 4'd2;
    localparam logic [3:0] EXT_BYTES64 = 4'd8;
    localparam logic [2:0] MASK_BYTES  = 3'd4;

    localparam logic [15:0] KEEP_LIMIT_RESET = 16'd512;

    // One accepted input beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_connection;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_present;
        logic       kept;
        logic       frame_end;
        logic [3:0] frame_opcode;
        logic [2:0] action;
        logic       truncated;
    } t_result;

    function automatic logic [2:0] class_of(input logic [3:0] op);
        logic [2:0] act;
        case (op)
            OP_CONT, OP_TEXT: act = ACT_TEXT;
            OP_CLOSE:         act = ACT_CLOSE;
            OP_PING:          act = ACT_PING;
            OP_PONG:          act = ACT_PONG;
            default:          act = ACT_OTHER;
        endcase
        return act;
    endfunction

endpackage

// File: src/wsfp_if.sv
// Channel interfaces of the WebSocket frame parser: byte input, result output, config write.
interface wsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       new_connection;

    modport source (output valid, output rx_byte, output new_connection, input ready);
    modport sink   (input valid, input rx_byte, input new_connection, output ready);
endinterface

interface wsfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       data_present;
    logic       kept;
    logic       frame_end;
    logic [3:0] frame_opcode;
    logic [2:0] action;
    logic       truncated;

    modport source (output valid, output data_byte, output data_present, output kept,
                    output frame_end, output frame_opcode, output action,
                    output truncated, input ready);
    modport sink   (input valid, input data_byte, input data_present, input kept,
                    input frame_end, input frame_opcode, input action,
                    input truncated, output ready);
endinterface

interface wsfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] keep_limit;

    modport source (output valid, output keep_limit, input ready);
    modport sink   (input valid, input keep_limit, output ready);
endinterface

// File: src/wsfp_in_stage.sv
// Input register stage: captures one received byte beat per cycle while the core takes the held beat.
module wsfp_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wsfp_in_if.sink              i_in,
    input  logic                 i_take,
    output logic                 o_valid,
    output wsfp_pkg::t_in_beat   o_beat
);

    logic               r_valid;
    wsfp_pkg::t_in_beat r_beat;

    // Accept when empty or when the held beat moves on this cycle
    assign i_in.ready = !r_valid || i_take;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_beat.rx_byte        <= i_in.rx_byte;
            r_beat.new_connection <= i_in.new_connection;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// File: src/wsfp_core.sv
// Frame parse state, per-byte header/unmask logic and the result register.
module wsfp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_beat_valid,
    input  wsfp_pkg::t_in_beat   i_beat,
    input  logic [15:0]          i_keep_limit,
    output logic                 o_take,
    wsfp_out_if.source           o_out
);

    wsfp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_masked, n_masked;
    logic [63:0]      r_len, n_len;
    logic [3:0]       r_needed, n_needed;
    logic [3:0]       r_eseen, n_eseen, e_eseen;
    logic [31:0]      r_key, n_key;
    logic [2:0]       r_mseen, n_mseen, e_mseen;
    logic [63:0]      r_count, n_count, e_count;
    logic             r_stop, n_stop, e_stop;

    logic             r_out_valid;
    wsfp_pkg::t_result r_res;
    wsfp_pkg::t_result res;
    logic             res_valid;
    logic             adv;

    logic [7:0]       b;
    logic [6:0]       len7;
    logic [7:0]       key_byte;
    logic             ending;

    // Advance when the result slot is free or drains this cycle
    assign adv    = i_beat_valid && (!r_out_valid || o_out.ready);
    assign o_take = adv;
    assign b      = i_beat.rx_byte;
    assign len7   = b[6:0];

    // Parse one byte
    always_comb begin
        // New connection restarts the parser before this byte
        e_phase = i_beat.new_connection ? wsfp_pkg::PH_HDR1 : r_phase;
        e_count = i_beat.new_connection ? 64'd0 : r_count;
        e_mseen = i_beat.new_connection ? 3'd0 : r_mseen;
        e_eseen = i_beat.new_connection ? 4'd0 : r_eseen;
        e_stop  = i_beat.new_connection ? 1'b0 : r_stop;

        n_phase  = e_phase;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_len    = r_len;
        n_needed = r_needed;
        n_eseen  = e_eseen;
        n_key    = r_key;
        n_mseen  = e_mseen;
        n_count  = e_count;
        n_stop   = e_stop;

        res_valid        = 1'b0;
        ending           = 1'b0;
        res.data_byte    = 8'd0;
        res.data_present = 1'b0;
        res.kept         = 1'b0;
        key_byte         = r_key[8*e_count[1:0] +: 8];

        if (!e_stop) begin
            case (e_phase)
                wsfp_pkg::PH_HDR2: begin
                    n_masked = b[7];
                    n_mseen  = 3'd0;
                    if (len7 < wsfp_pkg::LEN_EXT16) begin
                        n_len   = {57'd0, len7};
                        n_count = 64'd0;
                        n_phase = b[7] ? wsfp_pkg::PH_MASK : wsfp_pkg::PH_PAY;
                        if (len7 == 7'd0 && !b[7]) begin
                            res_valid = 1'b1;
                            ending    = 1'b1;
                        end
                    end else begin
                        n_len    = 64'd0;
                        n_needed = (len7 == wsfp_pkg::LEN_EXT16) ? wsfp_pkg::EXT_BYTES16
                                                                 : wsfp_pkg::EXT_BYTES64;
                        n_eseen  = 4'd0;
                        n_phase  = wsfp_pkg::PH_EXT;
                    end
                end
                wsfp_pkg::PH_EXT: begin
                    n_len   = {r_len[55:0], b};
                    n_eseen = e_eseen + 4'd1;
                    if (n_eseen >= r_needed) begin
                        n_count = 64'd0;
                        n_phase = r_masked ? wsfp_pkg::PH_MASK : wsfp_pkg::PH_PAY;
                        if (n_len == 64'd0 && !r_masked) begin
                            res_valid = 1'b1;
                            ending    = 1'b1;
                        end
                    end
                end
                wsfp_pkg::PH_MASK: begin
                    n_key[8*e_mseen[1:0] +: 8] = b;
                    n_mseen = e_mseen + 3'd1;
                    if (n_mseen >= wsfp_pkg::MASK_BYTES) begin
                        n_count = 64'd0;
                        n_phase = wsfp_pkg::PH_PAY;
                        if (r_len == 64'd0) begin
                            res_valid = 1'b1;
                            ending    = 1'b1;
                        end
                    end
                end
                wsfp_pkg::PH_PAY: begin
                    res_valid        = 1'b1;
                    res.data_byte    = r_masked ? (b ^ key_byte) : b;
                    res.data_present = 1'b1;
                    res.kept         = (e_count[63:16] == 48'd0) &&
                                       (e_count[15:0] < i_keep_limit);
                    n_count          = e_count + 64'd1;
                    ending           = (n_count >= r_len);
                end
                default: begin
                    n_opcode = b[3:0];
                    n_phase  = wsfp_pkg::PH_HDR2;
                end
            endcase
        end

        // Frame end: classify, flag truncation, return to header one, stop on close
        res.frame_end    = ending;
        res.frame_opcode = r_opcode;
        res.action       = ending ? wsfp_pkg::class_of(r_opcode) : wsfp_pkg::ACT_MID;
        res.truncated    = ending && (n_count > {48'd0, i_keep_limit});
        if (ending) begin
            n_phase = wsfp_pkg::PH_HDR1;
            if (r_opcode == wsfp_pkg::OP_CLOSE) begin
                n_stop = 1'b1;
            end
        end
    end

    // Update parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfp_pkg::PH_HDR1;
            r_opcode <= 4'd0;
            r_masked <= 1'b0;
            r_len    <= 64'd0;
            r_needed <= 4'd0;
            r_eseen  <= 4'd0;
            r_key    <= 32'd0;
            r_mseen  <= 3'd0;
            r_count  <= 64'd0;
            r_stop   <= 1'b0;
        end else if (adv) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_needed <= n_needed;
            r_eseen  <= n_eseen;
            r_key    <= n_key;
            r_mseen  <= n_mseen;
            r_count  <= n_count;
            r_stop   <= n_stop;
        end
    end

    // Result valid: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data_byte    = r_res.data_byte;
    assign o_out.data_present = r_res.data_present;
    assign o_out.kept         = r_res.kept;
    assign o_out.frame_end    = r_res.frame_end;
    assign o_out.frame_opcode = r_res.frame_opcode;
    assign o_out.action       = r_res.action;
    assign o_out.truncated    = r_res.truncated;

    // A stopped parser produces no result unless a new connection restarts it
    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_stop && !i_beat.new_connection) |=> !r_out_valid)
        else $error("result produced while parser stopped");

    // The end of a close frame stops the parser
    a_close_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && res_valid && res.frame_end && r_opcode == wsfp_pkg::OP_CLOSE) |=> r_stop)
        else $error("close frame did not stop parser");

    // An empty result is always a frame end
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.data_present) |-> r_res.frame_end)
        else $error("empty result without frame end");

    // Action is set exactly on frame end
    a_action_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.action == wsfp_pkg::ACT_MID) == !r_res.frame_end))
        else $error("action and frame end disagree");

endmodule

// File: src/websocket_frame_parser.sv
// Top level of the WebSocket receive frame parser.
// Path: an accepted byte is held in the input register, and its payload or empty-frame result in the result register.
// Throughput: one byte per cycle while the output is not stalled; the header/unmask logic sits between the input
// register and the result register, and a stalled output backs up into the input stage and stops new bytes.
// Reset: synchronous active-low i_rst_n; parser to header one, keep limit to 512.
module websocket_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfp_in_if.sink     i_in,
    wsfp_cfg_if.sink    i_cfg,
    wsfp_out_if.source  o_out
);

    logic [15:0]        r_keep_limit;
    logic               take;
    logic               beat_valid;
    wsfp_pkg::t_in_beat beat;

    // Config writes are always taken
    assign i_cfg.ready = 1'b1;

    // Hold keep limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_limit <= wsfp_pkg::KEEP_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            r_keep_limit <= i_cfg.keep_limit;
        end
    end

    wsfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (beat_valid),
        .o_beat  (beat)
    );

    wsfp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .i_keep_limit (r_keep_limit),
        .o_take       (take),
        .o_out        (o_out)
    );

endmodule

// File: verif/websocket_frame_parser_tb.sv
// Self-checking testbench of the WebSocket frame parser: directed frames, then random byte streams.
module websocket_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes not named in the package, and the length of the ready hold-off
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] OP_RSVD_F = 4'hF;
    localparam int         HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsfp_in_if  in_ch ();
    wsfp_out_if out_ch ();
    wsfp_cfg_if cfg_ch ();

    websocket_frame_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // Deframer state as the parser should hold it
    wsfp_pkg::t_phase pr_phase;
    logic [3:0]  pr_opcode;
    logic        pr_masked;
    logic [63:0] pr_len;
    logic [3:0]  pr_ext_need;
    logic [3:0]  pr_ext_seen;
    logic [31:0] pr_key;
    logic [2:0]  pr_key_seen;
    logic [63:0] pr_count;
    logic        pr_stopped;
    logic [15:0] pr_keep_limit;

    wsfp_pkg::t_result expected_results[$];
    int      mismatches = 0;
    int      bytes_sent = 0;
    int      send_idle = 0;
    int      recv_stall = 0;
    bit      resync = 1'b0;
    logic    hold_go = 1'b0;
    bit      hold_taken = 1'b0;
    int      hold_left = 0;

    typedef struct {
        logic [7:0]        rx;
        logic              nc;
        bit                typed;
        wsfp_pkg::t_result want;
    } t_stim_row;

    t_stim_row directed_rows[$];

    function automatic logic [2:0] frame_class(logic [3:0] op);
        case (op)
            wsfp_pkg::OP_CONT, wsfp_pkg::OP_TEXT: return wsfp_pkg::ACT_TEXT;
            wsfp_pkg::OP_CLOSE:                   return wsfp_pkg::ACT_CLOSE;
            wsfp_pkg::OP_PING:                    return wsfp_pkg::ACT_PING;
            wsfp_pkg::OP_PONG:                    return wsfp_pkg::ACT_PONG;
            default:                              return wsfp_pkg::ACT_OTHER;
        endcase
    endfunction

    // Form one result beat; on frame end go back to header one, stop after a close
    function automatic wsfp_pkg::t_result shape_result(logic [7:0] d, logic present, logic kp,
                                                       logic ending);
        wsfp_pkg::t_result r;
        r.data_byte    = d;
        r.data_present = present;
        r.kept         = kp;
        r.frame_end    = ending;
        r.frame_opcode = pr_opcode;
        r.action       = ending ? frame_class(pr_opcode) : wsfp_pkg::ACT_MID;
        r.truncated    = ending && (pr_count > 64'(pr_keep_limit));
        if (ending) begin
            if (pr_opcode == wsfp_pkg::OP_CLOSE) pr_stopped = 1'b1;
            pr_phase = wsfp_pkg::PH_HDR1;
        end
        return r;
    endfunction

    // Advance the deframer by one byte; return 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [7:0] b, input logic nc,
                                        output wsfp_pkg::t_result r);
        logic [6:0] len7;
        logic [1:0] lane;
        logic [7:0] d;
        logic       kp;
        r = '0;
        if (nc) begin
            pr_phase    = wsfp_pkg::PH_HDR1;
            pr_count    = '0;
            pr_key_seen = '0;
            pr_ext_seen = '0;
            pr_stopped  = 1'b0;
        end
        if (pr_stopped) return 1'b0;
        case (pr_phase)
            wsfp_pkg::PH_HDR2: begin
                len7        = b[6:0];
                pr_masked   = b[7];
                pr_key_seen = '0;
                pr_len      = '0;
                if (len7 < wsfp_pkg::LEN_EXT16) begin
                    pr_len   = 64'(len7);
                    pr_count = '0;
                    pr_phase = pr_masked ? wsfp_pkg::PH_MASK : wsfp_pkg::PH_PAY;
                    if (len7 == 7'd0 && !pr_masked) begin
                        r = shape_result(8'h00, 1'b0, 1'b0, 1'b1);
                        return 1'b1;
                    end
                end else begin
                    pr_ext_need = (len7 == wsfp_pkg::LEN_EXT16) ? wsfp_pkg::EXT_BYTES16
                                                                : wsfp_pkg::EXT_BYTES64;
                    pr_ext_seen = '0;
                    pr_phase    = wsfp_pkg::PH_EXT;
                end
                return 1'b0;
            end
            wsfp_pkg::PH_EXT: begin
                pr_len      = {pr_len[55:0], b};
                pr_ext_seen = pr_ext_seen + 4'd1;
                if (pr_ext_seen >= pr_ext_need) begin
                    pr_count = '0;
                    pr_phase = pr_masked ? wsfp_pkg::PH_MASK : wsfp_pkg::PH_PAY;
                    if (pr_len == 64'd0 && !pr_masked) begin
                        r = shape_result(8'h00, 1'b0, 1'b0, 1'b1);
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            wsfp_pkg::PH_MASK: begin
                pr_key[pr_key_seen[1:0]*8 +: 8] = b;
                pr_key_seen = pr_key_seen + 3'd1;
                if (pr_key_seen >= wsfp_pkg::MASK_BYTES) begin
                    pr_count = '0;
                    pr_phase = wsfp_pkg::PH_PAY;
                    if (pr_len == 64'd0) begin
                        r = shape_result(8'h00, 1'b0, 1'b0, 1'b1);
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            wsfp_pkg::PH_PAY: begin
                lane     = pr_count[1:0];
                d        = pr_masked ? (b ^ pr_key[lane*8 +: 8]) : b;
                kp       = (pr_count < 64'(pr_keep_limit));
                pr_count = pr_count + 64'd1;
                r = shape_result(d, 1'b1, kp, pr_count >= pr_len);
                return 1'b1;
            end
            default: begin
                pr_opcode = b[3:0];
                pr_phase  = wsfp_pkg::PH_HDR2;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void add_row(logic [7:0] rx, logic nc, bit typed,
                                    wsfp_pkg::t_result want);
        t_stim_row row;
        row.rx    = rx;
        row.nc    = nc;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one byte, wait for its beat, then record what it should yield
    task automatic send_byte(input logic [7:0] b, input logic nc, input bit typed,
                             input wsfp_pkg::t_result want);
        wsfp_pkg::t_result r;
        bit      has_r;
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.rx_byte        <= b;
        in_ch.new_connection <= nc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (!(pr_stopped && !nc)) bytes_sent++;
        has_r = deframe_byte(b, nc, r);
        if (has_r) expected_results.push_back(typed ? want : r);
    endtask

    // Send one random frame, or noise, or a frame cut short
    task automatic send_frame();
        logic [7:0] fb[$];
        logic [3:0] op;
        logic       mask;
        logic       nc;
        int         len;
        int         pick;
        int         cut;
        nc     = resync || ($urandom_range(11) == 0);
        resync = 1'b0;
        // a stopped parser must swallow these
        if (pr_stopped && $urandom_range(1)) begin
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
        if (pr_stopped) nc = 1'b1;
        if ($urandom_range(14) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), nc, 1'b0, '0);
            resync = 1'b1;
            return;
        end
        case ($urandom_range(9))
            0:       op = wsfp_pkg::OP_CONT;
            1, 2:    op = wsfp_pkg::OP_TEXT;
            3:       op = wsfp_pkg::OP_CLOSE;
            4:       op = wsfp_pkg::OP_PING;
            5:       op = wsfp_pkg::OP_PONG;
            default: op = 4'($urandom_range(15));
        endcase
        mask = 1'($urandom_range(1));
        pick = $urandom_range(99);
        fb.push_back({4'($urandom_range(15)), op});
        if (pick < 60) begin
            len = $urandom_range(12);
            fb.push_back({mask, 7'(len)});
        end else if (pick < 63) begin
            len = $urandom_range(120, 125);
            fb.push_back({mask, 7'(len)});
        end else if (pick < 83) begin
            len = ($urandom_range(49) == 0) ? $urandom_range(256, 260) : $urandom_range(12);
            fb.push_back({mask, wsfp_pkg::LEN_EXT16});
            fb.push_back(8'(len >> 8));
            fb.push_back(8'(len));
        end else begin
            len = $urandom_range(12);
            fb.push_back({mask, LEN_EXT64});
            repeat (6) fb.push_back(8'h00);
            fb.push_back(8'(len >> 8));
            fb.push_back(8'(len));
        end
        if (mask) repeat (wsfp_pkg::MASK_BYTES) fb.push_back(8'($urandom_range(255)));
        repeat (len) fb.push_back(8'($urandom_range(255)));
        // cut the frame short now and then; the next frame reconnects
        cut = fb.size();
        if ($urandom_range(11) == 0) begin
            cut    = $urandom_range(1, fb.size() - 1);
            resync = 1'b1;
        end
        for (int i = 0; i < cut; i++) send_byte(fb[i], (i == 0) ? nc : 1'b0, 1'b0, '0);
    endtask

    // Drop valid, wait until every expected beat is back, then let the pipe empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_keep_limit(input logic [15:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.keep_limit <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid  <= 1'b0;
        pr_keep_limit  = v;
    endtask

    task automatic run_phase(input logic [15:0] keep, input int sidle, input int rstall,
                             input int n_bytes, input bit pressure);
        int start;
        settle();
        write_keep_limit(keep);
        send_idle  = sidle;
        recv_stall = rstall;
        if (pressure) hold_go <= 1'b1;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_frame();
    endtask

    // Drive result ready; one long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Compare each result beat with the oldest expected one
    always @(posedge i_clk) begin : result_check
        wsfp_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, data_byte %0h frame_end %0b",
                         $time, out_ch.data_byte, out_ch.frame_end);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("data_byte", want.data_byte, out_ch.data_byte);
                check_field("data_present", 8'(want.data_present), 8'(out_ch.data_present));
                check_field("kept", 8'(want.kept), 8'(out_ch.kept));
                check_field("frame_end", 8'(want.frame_end), 8'(out_ch.frame_end));
                check_field("frame_opcode", 8'(want.frame_opcode), 8'(out_ch.frame_opcode));
                check_field("action", 8'(want.action), 8'(out_ch.action));
                check_field("truncated", 8'(want.truncated), 8'(out_ch.truncated));
            end
        end
    end

    // Give up on a hung run
    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.rx_byte        <= 8'h00;
        in_ch.new_connection <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.keep_limit    <= 16'h0000;

        pr_phase      = wsfp_pkg::PH_HDR1;
        pr_opcode     = '0;
        pr_masked     = 1'b0;
        pr_len        = '0;
        pr_ext_need   = '0;
        pr_ext_seen   = '0;
        pr_key        = '0;
        pr_key_seen   = '0;
        pr_count      = '0;
        pr_stopped    = 1'b0;
        pr_keep_limit = wsfp_pkg::KEEP_LIMIT_RESET;

        // Empty unmasked text frame
        add_row(8'h81, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1,
                wsfp_pkg::t_result'{8'h00, 1'b0, 1'b0, 1'b1, wsfp_pkg::OP_TEXT,
                                    wsfp_pkg::ACT_TEXT, 1'b0});
        // Masked one-byte ping, all-ones key
        add_row(8'h89, 1'b0, 1'b0, '0);
        add_row(8'h81, 1'b0, 1'b0, '0);
        repeat (4) add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1,
                wsfp_pkg::t_result'{8'hFF, 1'b1, 1'b1, 1'b1, wsfp_pkg::OP_PING,
                                    wsfp_pkg::ACT_PING, 1'b0});
        // Masked empty pong with a 16-bit length: ends on the last key byte
        add_row(8'h8A, 1'b0, 1'b0, '0);
        add_row(8'hFE, 1'b0, 1'b0, '0);
        repeat (5) add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1,
                wsfp_pkg::t_result'{8'h00, 1'b0, 1'b0, 1'b1, wsfp_pkg::OP_PONG,
                                    wsfp_pkg::ACT_PONG, 1'b0});
        // Reserved opcode, unmasked 16-bit length of one
        add_row(8'h0F, 1'b0, 1'b0, '0);
        add_row(8'h7E, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1,
                wsfp_pkg::t_result'{8'hFF, 1'b1, 1'b1, 1'b1, OP_RSVD_F,
                                    wsfp_pkg::ACT_OTHER, 1'b0});
        // Empty close stops the parser; the next byte is dropped
        add_row(8'h88, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1,
                wsfp_pkg::t_result'{8'h00, 1'b0, 1'b0, 1'b1, wsfp_pkg::OP_CLOSE,
                                    wsfp_pkg::ACT_CLOSE, 1'b0});
        add_row(8'hAA, 1'b0, 1'b0, '0);
        // New connection restarts with an empty continuation
        add_row(8'h80, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1,
                wsfp_pkg::t_result'{8'h00, 1'b0, 1'b0, 1'b1, wsfp_pkg::OP_CONT,
                                    wsfp_pkg::ACT_TEXT, 1'b0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].rx, directed_rows[i].nc, directed_rows[i].typed,
                      directed_rows[i].want);
        end

        resync = 1'b1;
        run_phase(16'd0, 0, 0, 100, 1'b0);
        run_phase(16'hFFFF, 57, 0, 100, 1'b0);
        run_phase(16'd3, 0, 57, 100, 1'b0);
        run_phase(16'($urandom_range(40)), 38, 38, 100, 1'b0);
        run_phase(16'd1, 0, 0, 60, 1'b1);
        settle();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
